/* sv/fcce_pkg.sv */
`timescale 1ns / 1ps

package fcce_pkg;

  localparam int unsigned TableDepthDefault = 16384;
  localparam int unsigned ApbAddrW          = 4;

  localparam logic [14:0] EntriesReset = 15'd16384;
  localparam logic [7:0]  SpcReset     = 8'd8;
  localparam logic [31:0] BaseReset    = 32'h0000_0000;

  localparam logic [31:0] ChainEndMin      = 32'h0fff_fff8;
  localparam logic [31:0] FreeWord         = 32'h0000_0000;
  localparam logic [32:0] FirstDataCluster = 33'd2;

  localparam logic [1:0] REG_ENTRIES = 2'd0;
  localparam logic [1:0] REG_SPC     = 2'd1;
  localparam logic [1:0] REG_BASE    = 2'd2;

  typedef enum logic [1:0] {
    FUNC_WRITE,
    FUNC_READ,
    FUNC_WALK,
    FUNC_FREE
  } func_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_NULL,
    ST_NOFREE
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [27:0] cluster;
    logic [31:0] entry_value;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] link_value;
    logic [14:0] span_clusters;
    logic [32:0] span_lba;
    logic [21:0] span_sectors;
    logic        end_of_chain;
    logic [13:0] free_cluster;
  } res_t;

  typedef struct packed {
    logic [14:0] entries_in_use;
    logic [7:0]  clus_sectors;
    logic [31:0] data_region_lba;
  } cfg_t;

endpackage

/* sv/fcce_ram.sv */
`timescale 1ns / 1ps

module fcce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/fcce_regs.sv */
`timescale 1ns / 1ps

module fcce_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcce_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fcce_pkg::cfg_t                 cfg_o
);

  import fcce_pkg::*;

  logic [14:0] entries_q, entries_d;
  logic [7:0]  spc_q, spc_d;
  logic [31:0] base_q, base_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    entries_d = entries_q;
    spc_d     = spc_q;
    base_d    = base_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENTRIES: entries_d = pwdata[14:0];
        REG_SPC:     spc_d     = pwdata[7:0];
        REG_BASE:    base_d    = pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENTRIES: prdata = {17'd0, entries_q};
      REG_SPC:     prdata = {24'd0, spc_q};
      REG_BASE:    prdata = base_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= EntriesReset;
      spc_q     <= SpcReset;
      base_q    <= BaseReset;
    end else begin
      entries_q <= entries_d;
      spc_q     <= spc_d;
      base_q    <= base_d;
    end
  end

  assign cfg_o.entries_in_use  = entries_q;
  assign cfg_o.clus_sectors    = spc_q;
  assign cfg_o.data_region_lba = base_q;

endmodule

/* sv/fcce_seq.sv */
`timescale 1ns / 1ps

module fcce_seq #(
  parameter int unsigned TableDepth = fcce_pkg::TableDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fcce_pkg::cmd_t cmd_i,
  input  fcce_pkg::cfg_t cfg_i,
  output logic           result_valid_o,
  output fcce_pkg::res_t result_o
);

  import fcce_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned LimW  = $clog2(TableDepth + 1);
  localparam int unsigned SecW  = LimW + 8;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] c_q, c_d;
  logic [AddrW-1:0] cl_q, cl_d;
  logic [LimW-1:0]  count_q, count_d;
  logic [31:0]      link_q, link_d;
  logic [32:0]      lba_prod_q, lba_prod_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic [LimW-1:0]  lim;
  logic [LimW-1:0]  nxt;
  logic             more;
  logic             accept;
  logic             oor;
  logic [AddrW-1:0] cmd_addr;
  logic [32:0]      cl_ext;
  logic [40:0]      lba_mul;
  logic [SecW-1:0]  sec_mul;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  always_comb begin
    if (32'(cfg_i.entries_in_use) > 32'(TableDepth)) begin
      lim = LimW'(TableDepth);
    end else begin
      lim = LimW'(cfg_i.entries_in_use);
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign oor      = (cmd_i.cluster >= 28'(lim));
  assign cmd_addr = cmd_i.cluster[AddrW-1:0];
  assign nxt      = LimW'(c_q) + LimW'(1);
  assign more     = (nxt < lim);
  assign cl_ext   = 33'(cmd_i.cluster) - FirstDataCluster;
  assign lba_mul  = cl_ext * cfg_i.clus_sectors;
  assign sec_mul  = count_q * cfg_i.clus_sectors;

  // table port control
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = FreeWord;
    end else begin
      ram_we    = accept && (cmd_i.func == FUNC_WRITE) && !oor;
      ram_waddr = cmd_addr;
      ram_wdata = cmd_i.entry_value;
    end
    if (state_q == S_IDLE) begin
      ram_raddr = cmd_addr;
    end else begin
      ram_raddr = nxt[AddrW-1:0];
    end
  end

  fcce_ram #(
    .Width (32),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    c_d         = c_q;
    cl_d        = cl_q;
    count_d     = count_q;
    link_d      = link_q;
    lba_prod_d  = lba_prod_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(TableDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_d      = '0;
          c_d        = cmd_addr;
          cl_d       = cmd_addr;
          lba_prod_d = lba_mul[32:0];
          unique case (cmd_i.func)
            FUNC_WRITE: begin
              res_valid_d = 1'b1;
              if (oor) begin
                res_d.status = ST_RANGE;
              end
            end
            FUNC_READ: begin
              if (oor) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            FUNC_WALK: begin
              if (oor) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_RANGE;
              end else if (cmd_i.cluster == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_NULL;
              end else begin
                state_d = S_WALK;
              end
            end
            FUNC_FREE: begin
              if (oor) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_NOFREE;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_d.link_value = ram_rdata;
        res_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      S_WALK: begin
        if (more && (ram_rdata == 32'(nxt))) begin
          c_d = nxt[AddrW-1:0];
        end else begin
          link_d  = ram_rdata;
          count_d = LimW'(c_q) - LimW'(cl_q) + LimW'(1);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d.status        = ST_OK;
        res_d.link_value    = link_q;
        res_d.span_clusters = 15'(count_q);
        res_d.span_lba      = lba_prod_q + 33'(cfg_i.data_region_lba);
        res_d.span_sectors  = 22'(sec_mul);
        res_d.end_of_chain  = (link_q >= ChainEndMin);
        res_d.free_cluster  = '0;
        res_valid_d         = 1'b1;
        state_d             = S_IDLE;
      end
      S_SCAN: begin
        if (ram_rdata == FreeWord) begin
          res_d.free_cluster = 14'(c_q);
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else if (more) begin
          c_d = nxt[AddrW-1:0];
        end else begin
          res_d.status = ST_NOFREE;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    cl_q       <= cl_d;
    count_q    <= count_d;
    link_q     <= link_d;
    lba_prod_q <= lba_prod_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTH
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !res_valid_q)
    else $error("result strobe during table clear");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) || (state_q == S_SCAN)) |-> (LimW'(c_q) < lim))
    else $error("cursor beyond table limit");

  a_span_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.span_clusters != '0)) |-> (res_q.status == ST_OK))
    else $error("span length with error status");

  a_nofree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == ST_NOFREE)) |-> (res_q.free_cluster == '0))
    else $error("free cluster set with no free status");

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> ((state_q == S_IDLE) && res_valid_q))
    else $error("span finish did not emit a result");
`endif

endmodule

/* sv/fat_cluster_chain_engine.sv */
`timescale 1ns / 1ps

// channel   handshake                        payload
// command   start, busy (accept: start&!busy) cmd_i (func, cluster, entry_value)
// result    result_valid_o, one-cycle strobe  result_o (status .. free_cluster)
// config    apb psel/penable/pwrite, pready=1 paddr, pwdata, prdata
//
// write: result in the cycle after accept; read: the table read is registered, then S_READ registers the result
// span walk of n clusters: S_WALK with one table read per cycle, then S_FIN registers the result
// free search over k entries: S_SCAN with one table read per cycle, result registered on a hit or at the limit
// after reset the table ram is cleared one entry per cycle, all TableDepth entries, busy high
// results cannot be stalled; a new command may be accepted in the cycle a result is shown

module fat_cluster_chain_engine #(
  parameter int unsigned TableDepth = fcce_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fcce_pkg::cmd_t                cmd_i,
  output logic                          result_valid_o,
  output fcce_pkg::res_t                result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcce_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import fcce_pkg::*;

  cfg_t cfg;

  fcce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcce_seq #(
    .TableDepth (TableDepth)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .cfg_i          (cfg),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
